@@ rtl/core/mpc_pkg.sv @@
// Shared types and constants of the Modbus PDU checker.
// Used by mpc_capture, mpc_check and modbus_pdu_checker_core; no dependencies.
package mpc_pkg;

   // Function codes that the checker knows.
   localparam logic [7:0] FC_READ_COILS      = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE   = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
   localparam logic [7:0] FC_READ_INPUT      = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
   localparam logic [7:0] FC_WRITE_REGISTER  = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS     = 8'h0f;
   localparam logic [7:0] FC_WRITE_REGISTERS = 8'h10;

   // Check codes; a function's exception format error is its base code plus one.
   localparam logic [4:0] CODE_OK                 = 5'd0;
   localparam logic [4:0] CODE_READ_COILS         = 5'd1;
   localparam logic [4:0] CODE_READ_DISCRETE      = 5'd3;
   localparam logic [4:0] CODE_READ_HOLDING       = 5'd5;
   localparam logic [4:0] CODE_READ_INPUT         = 5'd7;
   localparam logic [4:0] CODE_WRITE_COIL         = 5'd9;
   localparam logic [4:0] CODE_WRITE_REGISTER     = 5'd11;
   localparam logic [4:0] CODE_WRITE_COILS        = 5'd13;
   localparam logic [4:0] CODE_WRITE_REGISTERS    = 5'd15;
   localparam logic [4:0] CODE_BAD_FUNC           = 5'd17;

   // Limits.
   localparam logic [15:0] MAX_READ_BITS   = 16'd2000;
   localparam logic [15:0] MAX_READ_REGS   = 16'd125;
   localparam logic [15:0] MAX_WRITE_COILS = 16'h07b0;
   localparam logic [15:0] MAX_WRITE_REGS  = 16'h007b;
   localparam logic [15:0] COIL_ON         = 16'hff00;
   localparam logic [15:0] COIL_OFF        = 16'h0000;
   localparam logic [7:0]  FUNC_MASK       = 8'h7f;
   localparam logic [7:0]  EXC_FLAG        = 8'h80;
   localparam logic [7:0]  EXC_MIN         = 8'd1;
   localparam logic [7:0]  EXC_MAX         = 8'd4;

   localparam int unsigned HEAD_DEPTH = 6;
   localparam int unsigned KEPT_DEPTH = 5;
   localparam logic [7:0]  LEN_MAX    = 8'd255;

   // One finished PDU as handed from the capture stage to the check stage.
   typedef struct packed {
      logic [HEAD_DEPTH-1:0][7:0] head;
      logic [7:0]                 len;
      logic                       is_rsp;
   } pdu_snap_type;

endpackage

@@ rtl/core/mpc_capture.sv @@
// Byte accumulator of the Modbus PDU checker: counts bytes, keeps the first six,
// and registers a snapshot of each finished PDU. Depends on mpc_pkg.
module mpc_capture (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 in_is_rsp,
   output logic                 snap_valid,
   input  logic                 snap_ready,
   output mpc_pkg::pdu_snap_type snap
);

   logic [7:0]                         count_ff, count_in;
   logic [mpc_pkg::HEAD_DEPTH-1:0][7:0] head_ff, head_in;
   logic [mpc_pkg::HEAD_DEPTH-1:0][7:0] head_upd;
   logic [7:0]                         count_upd;
   logic                               snap_valid_ff, snap_valid_in;
   mpc_pkg::pdu_snap_type              snap_ff, snap_in;
   logic                               accept;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   // Head and length as they stand with the current byte included.
   always_comb begin
      for (int i = 0; i < mpc_pkg::HEAD_DEPTH; i++) begin
         head_upd[i] = (count_ff == 8'(i)) ? in_byte : head_ff[i];
      end
      count_upd = (count_ff < mpc_pkg::LEN_MAX) ? count_ff + 8'd1 : count_ff;
   end

   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff;
      if (snap_ready) begin
         snap_valid_in = 1'b0;
      end
      if (accept) begin
         if (in_last) begin
            count_in       = '0;
            head_in        = '0;
            snap_in.head   = head_upd;
            snap_in.len    = count_upd;
            snap_in.is_rsp = in_is_rsp;
            snap_valid_in  = 1'b1;
         end else begin
            count_in = count_upd;
            head_in  = head_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         head_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         head_ff       <= head_in;
         snap_valid_ff <= snap_valid_in;
      end
      snap_ff <= snap_in;
   end

endmodule

@@ rtl/core/mpc_check.sv @@
// Check stage of the Modbus PDU checker: validates one finished PDU, a request on its own
// or a response against the kept request, and registers the check code. Depends on mpc_pkg.
module mpc_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_valid,
   output logic                  snap_ready,
   input  mpc_pkg::pdu_snap_type snap,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [4:0]            out_code,
   output logic                  out_is_rsp
);

   logic [mpc_pkg::KEPT_DEPTH-1:0][7:0] kept_ff, kept_in;
   logic                               out_valid_ff, out_valid_in;
   logic [4:0]                         code_ff, code_in;
   logic                               is_rsp_ff, is_rsp_in;
   logic                               take;

   // Request check signals.
   logic [15:0] rq_qty, rq_len_m6, rq_coil_bytes, rq_reg_bytes, rq_byte_cnt;
   logic        rq_len5, rq_has6, rq_fail;
   logic [4:0]  rq_base, rq_code;
   // Response check signals.
   logic [7:0]  rs_func, kept_func;
   logic [15:0] rs_kept_qty, rs_need, rs_len_m2, rs_p1;
   logic        rs_exc, rs_fail, rs_known, rs_exc_bad, rs_echo;
   logic [4:0]  rs_base, rs_code;

   assign snap_ready = !out_valid_ff || out_ready;
   assign take       = snap_valid && snap_ready;
   assign out_valid  = out_valid_ff;
   assign out_code   = code_ff;
   assign out_is_rsp = is_rsp_ff;

   // Request on its own.
   always_comb begin
      rq_qty        = {snap.head[3], snap.head[4]};
      rq_len5       = (snap.len == 8'd5);
      rq_has6       = (snap.len >= 8'd6);
      rq_len_m6     = {8'd0, snap.len} - 16'd6;
      rq_coil_bytes = (rq_qty >> 3) + {15'd0, (rq_qty[2:0] != 3'd0)};
      rq_reg_bytes  = {rq_qty[14:0], 1'b0};
      rq_byte_cnt   = {8'd0, snap.head[5]};
      rq_fail       = 1'b0;
      rq_base       = mpc_pkg::CODE_BAD_FUNC;
      case (snap.head[0])
         mpc_pkg::FC_READ_COILS: begin
            rq_base = mpc_pkg::CODE_READ_COILS;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_READ_BITS || !rq_len5;
         end
         mpc_pkg::FC_READ_DISCRETE: begin
            rq_base = mpc_pkg::CODE_READ_DISCRETE;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_READ_BITS || !rq_len5;
         end
         mpc_pkg::FC_READ_HOLDING: begin
            rq_base = mpc_pkg::CODE_READ_HOLDING;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_READ_REGS || !rq_len5;
         end
         mpc_pkg::FC_READ_INPUT: begin
            rq_base = mpc_pkg::CODE_READ_INPUT;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_READ_REGS || !rq_len5;
         end
         mpc_pkg::FC_WRITE_COIL: begin
            rq_base = mpc_pkg::CODE_WRITE_COIL;
            rq_fail = (rq_qty != mpc_pkg::COIL_OFF && rq_qty != mpc_pkg::COIL_ON)
                      || !rq_len5;
         end
         mpc_pkg::FC_WRITE_REGISTER: begin
            rq_base = mpc_pkg::CODE_WRITE_REGISTER;
            rq_fail = !rq_len5;
         end
         mpc_pkg::FC_WRITE_COILS: begin
            rq_base = mpc_pkg::CODE_WRITE_COILS;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_WRITE_COILS
                      || rq_byte_cnt != rq_coil_bytes || !rq_has6
                      || rq_coil_bytes != rq_len_m6;
         end
         mpc_pkg::FC_WRITE_REGISTERS: begin
            rq_base = mpc_pkg::CODE_WRITE_REGISTERS;
            rq_fail = rq_qty == 16'd0 || rq_qty > mpc_pkg::MAX_WRITE_REGS
                      || rq_byte_cnt != rq_reg_bytes || !rq_has6
                      || rq_reg_bytes != rq_len_m6;
         end
         default: begin
            rq_base = mpc_pkg::CODE_BAD_FUNC;
            rq_fail = 1'b1;
         end
      endcase
      rq_code = rq_fail ? rq_base : mpc_pkg::CODE_OK;
   end

   // Response against the kept request.
   always_comb begin
      rs_func     = snap.head[0] & mpc_pkg::FUNC_MASK;
      kept_func   = kept_ff[0] & mpc_pkg::FUNC_MASK;
      rs_exc      = (snap.head[0] & mpc_pkg::EXC_FLAG) != 8'd0;
      rs_kept_qty = {kept_ff[3], kept_ff[4]};
      rs_p1       = {8'd0, snap.head[1]};
      rs_len_m2   = {8'd0, snap.len} - 16'd2;
      rs_known    = 1'b1;
      rs_base     = mpc_pkg::CODE_BAD_FUNC;
      case (rs_func)
         mpc_pkg::FC_READ_COILS:      rs_base = mpc_pkg::CODE_READ_COILS;
         mpc_pkg::FC_READ_DISCRETE:   rs_base = mpc_pkg::CODE_READ_DISCRETE;
         mpc_pkg::FC_READ_HOLDING:    rs_base = mpc_pkg::CODE_READ_HOLDING;
         mpc_pkg::FC_READ_INPUT:      rs_base = mpc_pkg::CODE_READ_INPUT;
         mpc_pkg::FC_WRITE_COIL:      rs_base = mpc_pkg::CODE_WRITE_COIL;
         mpc_pkg::FC_WRITE_REGISTER:  rs_base = mpc_pkg::CODE_WRITE_REGISTER;
         mpc_pkg::FC_WRITE_COILS:     rs_base = mpc_pkg::CODE_WRITE_COILS;
         mpc_pkg::FC_WRITE_REGISTERS: rs_base = mpc_pkg::CODE_WRITE_REGISTERS;
         default:                     rs_known = 1'b0;
      endcase
      // Read functions answer with a byte count; the others echo address and quantity.
      if (rs_func <= mpc_pkg::FC_READ_DISCRETE) begin
         rs_need = (rs_kept_qty >> 3) + {15'd0, (rs_kept_qty[2:0] != 3'd0)};
      end else begin
         rs_need = {rs_kept_qty[14:0], 1'b0};
      end
      rs_echo    = {kept_ff[1], kept_ff[2]} == {snap.head[1], snap.head[2]}
                   && rs_kept_qty == {snap.head[3], snap.head[4]};
      rs_exc_bad = snap.head[1] < mpc_pkg::EXC_MIN || snap.head[1] > mpc_pkg::EXC_MAX;
      if (rs_func <= mpc_pkg::FC_READ_INPUT) begin
         rs_fail = rs_need != rs_p1 || snap.len < 8'd2 || rs_need != rs_len_m2;
      end else begin
         rs_fail = !rs_echo || snap.len != 8'd5;
      end
      if (rs_func != kept_func || !rs_known) begin
         rs_code = mpc_pkg::CODE_BAD_FUNC;
      end else if (rs_exc) begin
         rs_code = rs_exc_bad ? rs_base + 5'd1 : mpc_pkg::CODE_OK;
      end else begin
         rs_code = rs_fail ? rs_base : mpc_pkg::CODE_OK;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      is_rsp_in    = is_rsp_ff;
      kept_in      = kept_ff;
      if (out_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
         is_rsp_in    = snap.is_rsp;
         code_in      = snap.is_rsp ? rs_code : rq_code;
         // Every request is kept, whatever its check code.
         if (!snap.is_rsp) begin
            for (int i = 0; i < mpc_pkg::KEPT_DEPTH; i++) begin
               kept_in[i] = snap.head[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         kept_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         kept_ff      <= kept_in;
      end
      code_ff   <= code_in;
      is_rsp_ff <= is_rsp_in;
   end

endmodule

@@ rtl/core/modbus_pdu_checker_core.sv @@
// Top level of the Modbus PDU checker: byte capture stage followed by check stage.
// Depends on mpc_pkg, mpc_capture and mpc_check.
//
//   channel | dir | tdata            | tuser            | tlast
//   req_    | in  | [7:0] pdu_byte   | [0] op           | last
//   rsp_    | out | [4:0] check_code | [0] was_response | -
//
// One request byte is taken every cycle unless the input stalls. A PDU's result passes
// from its last byte into the capture snapshot register, then through the check logic
// into the result register. Reset is synchronous and clears the byte count, the stored
// head bytes and the kept request. A stalled result stops the check stage, and the input
// stalls only when a second finished PDU is waiting.
module modbus_pdu_checker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] pdu_byte
   input  logic       req_tuser,  // [0] op
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [4:0] check_code, [7:5] zero
   output logic       rsp_tuser   // [0] was_response
);

   logic                  snap_valid;
   logic                  snap_ready;
   mpc_pkg::pdu_snap_type snap;
   logic [4:0]            code;

   mpc_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .in_is_rsp  (req_tuser),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   mpc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_code   (code),
      .out_is_rsp (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, code};

   // A finished PDU always lands in the snapshot register.
   a_last_snapped: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> snap_valid)
      else $error("finished request PDU not captured");

   // Check codes never exceed the unsupported-function code.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (code <= mpc_pkg::CODE_BAD_FUNC))
      else $error("check code out of range");

   // A request can only fail with an odd code.
   a_request_odd: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && code != mpc_pkg::CODE_OK) |-> code[0])
      else $error("even check code on a request");

endmodule

@@ tb/mpc_verdict_checker.sv @@
// Checker for the Modbus PDU checker core: watches both streams, predicts each verdict.
// Depends on mpc_pkg; instantiated beside the block by tb_modbus_pdu_checker_core.
module mpc_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [4:0] code;
      logic       was_rsp;
   } verdict_type;

   verdict_type due_verdicts[$];

   logic [7:0] pdu_len;
   logic [7:0] head [mpc_pkg::HEAD_DEPTH];
   logic [7:0] kept [mpc_pkg::KEPT_DEPTH];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string what, input int got, input int want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic logic [15:0] coil_byte_count(input logic [15:0] q);
      return (q >> 3) + ((q[2:0] != 3'd0) ? 16'd1 : 16'd0);
   endfunction

   function automatic logic [4:0] request_verdict();
      logic [15:0] q;
      logic [15:0] j;
      int          len;
      logic        len5;
      logic        has6;
      q    = {head[3], head[4]};
      len  = int'(pdu_len);
      len5 = (len == 5);
      has6 = (len >= 6);
      case (head[0])
         mpc_pkg::FC_READ_COILS:
            return (q < 1 || q > mpc_pkg::MAX_READ_BITS || !len5)
                   ? mpc_pkg::CODE_READ_COILS : mpc_pkg::CODE_OK;
         mpc_pkg::FC_READ_DISCRETE:
            return (q < 1 || q > mpc_pkg::MAX_READ_BITS || !len5)
                   ? mpc_pkg::CODE_READ_DISCRETE : mpc_pkg::CODE_OK;
         mpc_pkg::FC_READ_HOLDING:
            return (q < 1 || q > mpc_pkg::MAX_READ_REGS || !len5)
                   ? mpc_pkg::CODE_READ_HOLDING : mpc_pkg::CODE_OK;
         mpc_pkg::FC_READ_INPUT:
            return (q < 1 || q > mpc_pkg::MAX_READ_REGS || !len5)
                   ? mpc_pkg::CODE_READ_INPUT : mpc_pkg::CODE_OK;
         mpc_pkg::FC_WRITE_COIL:
            return ((q != mpc_pkg::COIL_OFF && q != mpc_pkg::COIL_ON) || !len5)
                   ? mpc_pkg::CODE_WRITE_COIL : mpc_pkg::CODE_OK;
         mpc_pkg::FC_WRITE_REGISTER:
            return len5 ? mpc_pkg::CODE_OK : mpc_pkg::CODE_WRITE_REGISTER;
         mpc_pkg::FC_WRITE_COILS: begin
            j = coil_byte_count(q);
            return (q < 1 || q > mpc_pkg::MAX_WRITE_COILS || {8'h00, head[5]} != j
                    || !has6 || int'(j) != len - 6)
                   ? mpc_pkg::CODE_WRITE_COILS : mpc_pkg::CODE_OK;
         end
         mpc_pkg::FC_WRITE_REGISTERS: begin
            // The byte count is twice the quantity, kept to 16 bits.
            j = {q[14:0], 1'b0};
            return (q < 1 || q > mpc_pkg::MAX_WRITE_REGS || {8'h00, head[5]} != j
                    || !has6 || int'(j) != len - 6)
                   ? mpc_pkg::CODE_WRITE_REGISTERS : mpc_pkg::CODE_OK;
         end
         default: return mpc_pkg::CODE_BAD_FUNC;
      endcase
   endfunction

   function automatic logic [4:0] response_verdict();
      logic [7:0]  fc;
      logic [4:0]  base;
      logic [15:0] q;
      logic [15:0] j;
      int          len;
      fc  = head[0] & mpc_pkg::FUNC_MASK;
      len = int'(pdu_len);
      if (fc != (kept[0] & mpc_pkg::FUNC_MASK)) return mpc_pkg::CODE_BAD_FUNC;
      case (fc)
         mpc_pkg::FC_READ_COILS:      base = mpc_pkg::CODE_READ_COILS;
         mpc_pkg::FC_READ_DISCRETE:   base = mpc_pkg::CODE_READ_DISCRETE;
         mpc_pkg::FC_READ_HOLDING:    base = mpc_pkg::CODE_READ_HOLDING;
         mpc_pkg::FC_READ_INPUT:      base = mpc_pkg::CODE_READ_INPUT;
         mpc_pkg::FC_WRITE_COIL:      base = mpc_pkg::CODE_WRITE_COIL;
         mpc_pkg::FC_WRITE_REGISTER:  base = mpc_pkg::CODE_WRITE_REGISTER;
         mpc_pkg::FC_WRITE_COILS:     base = mpc_pkg::CODE_WRITE_COILS;
         mpc_pkg::FC_WRITE_REGISTERS: base = mpc_pkg::CODE_WRITE_REGISTERS;
         default:                     return mpc_pkg::CODE_BAD_FUNC;
      endcase
      if ((head[0] & mpc_pkg::EXC_FLAG) != 8'h00)
         return (head[1] < mpc_pkg::EXC_MIN || head[1] > mpc_pkg::EXC_MAX)
                ? 5'(base + 5'd1) : mpc_pkg::CODE_OK;
      if (fc <= mpc_pkg::FC_READ_INPUT) begin
         q = {kept[3], kept[4]};
         j = (fc <= mpc_pkg::FC_READ_DISCRETE) ? coil_byte_count(q) : {q[14:0], 1'b0};
         return (j != {8'h00, head[1]} || len < 2 || int'(j) != len - 2)
                ? base : mpc_pkg::CODE_OK;
      end
      // Writes echo the address and the quantity or value of the request.
      return ({kept[1], kept[2]} != {head[1], head[2]}
              || {kept[3], kept[4]} != {head[3], head[4]}
              || len != 5) ? base : mpc_pkg::CODE_OK;
   endfunction

   always @(posedge clock) begin : monitor
      verdict_type due;
      logic [4:0]  code;
      if (reset) begin
         due_verdicts.delete();
         pdu_len = 8'd0;
         for (int k = 0; k < mpc_pkg::HEAD_DEPTH; k++) head[k] = 8'h00;
         for (int k = 0; k < mpc_pkg::KEPT_DEPTH; k++) kept[k] = 8'h00;
      end else begin
         // A result leaving now belongs to an older PDU than one ending now.
         if (rsp_tvalid && rsp_tready) begin
            if (due_verdicts.size() == 0) begin
               report("result with no PDU waiting", int'(rsp_tdata), -1);
            end else begin
               due = due_verdicts.pop_front();
               if (rsp_tdata[4:0] != due.code)
                  report("check_code", int'(rsp_tdata[4:0]), int'(due.code));
               if (rsp_tdata[7:5] != 3'd0)
                  report("rsp_tdata pad bits", int'(rsp_tdata[7:5]), 0);
               if (rsp_tuser != due.was_rsp)
                  report("was_response", int'(rsp_tuser), int'(due.was_rsp));
            end
         end
         if (req_tvalid && req_tready) begin
            if (pdu_len < mpc_pkg::HEAD_DEPTH) head[pdu_len] = req_tdata;
            if (pdu_len != mpc_pkg::LEN_MAX) pdu_len = pdu_len + 8'd1;
            if (req_tlast) begin
               if (req_tuser) begin
                  code = response_verdict();
               end else begin
                  code = request_verdict();
                  for (int k = 0; k < mpc_pkg::KEPT_DEPTH; k++) kept[k] = head[k];
               end
               due_verdicts.push_back('{code: code, was_rsp: req_tuser});
               pdu_len = 8'd0;
               for (int k = 0; k < mpc_pkg::HEAD_DEPTH; k++) head[k] = 8'h00;
            end
         end
      end
      pending <= due_verdicts.size();
   end

endmodule

@@ tb/tb_modbus_pdu_checker_core.sv @@
// Testbench top of the Modbus PDU checker core: clock, reset, PDU stimulus and verdict.
// Depends on mpc_pkg, modbus_pdu_checker_core and mpc_verdict_checker.
module tb_modbus_pdu_checker_core;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   int         fail_count;
   int         pending;

   logic [7:0] pdu [$];
   logic [7:0] last_req [mpc_pkg::KEPT_DEPTH];
   int         bytes_sent = 0;
   bit         gaps_on    = 1'b1;
   bit         quiet      = 1'b0;
   bit         hold_on    = 1'b0;

   logic [7:0] known_fc [8] = '{mpc_pkg::FC_READ_COILS, mpc_pkg::FC_READ_DISCRETE,
                                mpc_pkg::FC_READ_HOLDING, mpc_pkg::FC_READ_INPUT,
                                mpc_pkg::FC_WRITE_COIL, mpc_pkg::FC_WRITE_REGISTER,
                                mpc_pkg::FC_WRITE_COILS, mpc_pkg::FC_WRITE_REGISTERS};

   localparam int HOLD_CYCLES = 80;

   always #2 clock = ~clock;

   modbus_pdu_checker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   mpc_verdict_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Result side: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_on) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sends the bytes in pdu as one PDU; valid is left high at its end unless a random gap follows.
   task automatic send_pdu(input bit as_rsp, input bit mix_op);
      int n;
      n = pdu.size();
      for (int k = 0; k < n; k++) begin
         req_tvalid <= 1'b1;
         req_tdata  <= pdu[k];
         req_tlast  <= (k == n - 1);
         req_tuser  <= (k == n - 1 || !mix_op) ? as_rsp : 1'($urandom_range(0, 1));
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
         if (gaps_on && $urandom_range(0, 11) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
      if (!as_rsp)
         for (int k = 0; k < mpc_pkg::KEPT_DEPTH; k++)
            last_req[k] = (k < n) ? pdu[k] : 8'h00;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic make_request(input logic [7:0] fc, input bit big);
      logic [15:0] addr;
      logic [15:0] q;
      int          nb;
      addr = 16'($urandom);
      case (fc)
         mpc_pkg::FC_READ_COILS, mpc_pkg::FC_READ_DISCRETE:
            q = big ? mpc_pkg::MAX_READ_BITS : 16'($urandom_range(1, 40));
         mpc_pkg::FC_READ_HOLDING, mpc_pkg::FC_READ_INPUT:
            q = big ? mpc_pkg::MAX_READ_REGS : 16'($urandom_range(1, 20));
         mpc_pkg::FC_WRITE_COIL:
            q = $urandom_range(0, 1) ? mpc_pkg::COIL_ON : mpc_pkg::COIL_OFF;
         mpc_pkg::FC_WRITE_COILS:
            q = big ? mpc_pkg::MAX_WRITE_COILS : 16'($urandom_range(1, 40));
         mpc_pkg::FC_WRITE_REGISTERS:
            q = big ? mpc_pkg::MAX_WRITE_REGS : 16'($urandom_range(1, 10));
         default:
            q = 16'($urandom);
      endcase
      pdu = {fc, addr[15:8], addr[7:0], q[15:8], q[7:0]};
      if (fc == mpc_pkg::FC_WRITE_COILS || fc == mpc_pkg::FC_WRITE_REGISTERS) begin
         nb = (fc == mpc_pkg::FC_WRITE_COILS) ? (int'(q) + 7) / 8 : 2 * int'(q);
         pdu.push_back(8'(nb));
         repeat (nb) pdu.push_back(8'($urandom));
      end
   endtask

   // Builds a response to the last request sent.
   task automatic make_response(input bit exc);
      logic [7:0]  fc;
      logic [15:0] q;
      int          j;
      fc = last_req[0] & mpc_pkg::FUNC_MASK;
      if (exc) begin
         pdu = {fc | mpc_pkg::EXC_FLAG,
                ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 4))
                                          : 8'($urandom_range(0, 1) * 5)};
      end else if (fc >= mpc_pkg::FC_READ_COILS && fc <= mpc_pkg::FC_READ_INPUT) begin
         q = {last_req[3], last_req[4]};
         j = (fc <= mpc_pkg::FC_READ_DISCRETE) ? (int'(q) + 7) / 8
                                               : (2 * int'(q)) & 16'hffff;
         if (j > 250) j = $urandom_range(0, 8);
         pdu = {fc, 8'(j)};
         repeat (j) pdu.push_back(8'($urandom));
      end else begin
         pdu = {fc, last_req[1], last_req[2], last_req[3], last_req[4]};
      end
   endtask

   task automatic corrupt_pdu();
      case ($urandom_range(0, 2))
         0:       pdu[$urandom_range(0, pdu.size() - 1)] = 8'($urandom);
         1:       if (pdu.size() > 1) void'(pdu.pop_back());
         default: pdu.push_back(8'($urandom));
      endcase
   endtask

   task automatic make_noise(input int lo, input int hi);
      pdu = {};
      repeat ($urandom_range(lo, hi)) pdu.push_back(8'($urandom));
   endtask

   initial begin
      int         pick;
      logic [7:0] fc;
      for (int k = 0; k < mpc_pkg::KEPT_DEPTH; k++) last_req[k] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed PDUs: limits, every function, exceptions and odd lengths.
      pdu = {mpc_pkg::FC_READ_COILS, 8'h00, 8'h00, 8'h00, 8'h01};          send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_COILS, 8'h01, 8'hff};                        send_pdu(1, 0);
      pdu = {mpc_pkg::FC_READ_DISCRETE, 8'hff, 8'hff, 8'h07, 8'hd1};       send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_HOLDING, 8'h00, 8'h10, 8'h00, 8'h7d};        send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_HOLDING | mpc_pkg::EXC_FLAG, 8'h04};         send_pdu(1, 0);
      pdu = {mpc_pkg::FC_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h00};          send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_INPUT | mpc_pkg::EXC_FLAG, 8'h00};           send_pdu(1, 0);
      pdu = {mpc_pkg::FC_WRITE_COIL, 8'h00, 8'h05, 8'hff, 8'h00};          send_pdu(0, 0);
      pdu = {mpc_pkg::FC_WRITE_COIL, 8'h00, 8'h05, 8'hff, 8'h00};          send_pdu(1, 0);
      pdu = {mpc_pkg::FC_WRITE_COIL, 8'h00, 8'h05, 8'h12, 8'h34};          send_pdu(0, 0);
      pdu = {mpc_pkg::FC_WRITE_REGISTER, 8'h00, 8'h01, 8'h12, 8'h34, 8'h56};  send_pdu(0, 0);
      pdu = {mpc_pkg::FC_WRITE_COILS, 8'h00, 8'h20, 8'h00, 8'h09, 8'h02, 8'hff, 8'h01};
      send_pdu(0, 0);
      pdu = {mpc_pkg::FC_WRITE_COILS, 8'h00, 8'h21, 8'h00, 8'h09};         send_pdu(1, 0);
      pdu = {mpc_pkg::FC_WRITE_REGISTERS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'hab, 8'hcd};
      send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_HOLDING, 8'h02};                             send_pdu(1, 0);
      pdu = {mpc_pkg::FC_WRITE_REGISTERS};                                 send_pdu(1, 0);
      pdu = {8'h2b, 8'h0e};                                                send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_COILS};                                      send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_COILS};                                      send_pdu(1, 0);
      // Twice 0x8001 wraps to a byte count of two.
      pdu = {mpc_pkg::FC_READ_HOLDING, 8'h00, 8'h00, 8'h80, 8'h01};        send_pdu(0, 0);
      pdu = {mpc_pkg::FC_READ_HOLDING, 8'h02, 8'h5a, 8'ha5};               send_pdu(1, 0);
      pdu = {mpc_pkg::FC_WRITE_COIL, 8'h00, 8'h00, 8'h00, 8'h00};          send_pdu(0, 1);
      pdu = {8'hff, 8'h00};                                                send_pdu(1, 0);
      // A PDU longer than the length counter can hold.
      make_noise(299, 299);
      pdu[0] = mpc_pkg::FC_WRITE_COILS;
      send_pdu(0, 0);

      // Hold the result side off while single-byte PDUs keep arriving.
      drain();
      hold_on = 1'b1;
      repeat (16) begin
         make_noise(1, 1);
         send_pdu($urandom_range(0, 1), 0);
      end
      drain();

      while (bytes_sent < 1200) begin
         if (bytes_sent >= 1050) begin
            gaps_on = 1'b0;
            quiet   = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            fc = ($urandom_range(0, 19) == 0) ? 8'($urandom) : known_fc[$urandom_range(0, 7)];
            make_request(fc, $urandom_range(0, 39) == 0);
            if ($urandom_range(0, 6) == 0) corrupt_pdu();
            send_pdu(0, $urandom_range(0, 19) == 0);
            if ($urandom_range(0, 9) != 0) begin
               make_response($urandom_range(0, 4) == 0);
               if ($urandom_range(0, 7) == 0) corrupt_pdu();
               send_pdu(1, $urandom_range(0, 19) == 0);
            end
         end else if (pick < 78) begin
            make_response($urandom_range(0, 3) == 0);
            send_pdu(1, 0);
         end else if (pick < 98) begin
            if ($urandom_range(0, 59) == 0) make_noise(256, 300);
            else make_noise(1, 12);
            send_pdu($urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            drain();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_modbus_pdu_checker_core: PASS");
      end else begin
         $display("tb_modbus_pdu_checker_core: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_modbus_pdu_checker_core: FAIL");
      $finish;
   end

endmodule
